@@ rtl/core/pwm_duty_average_mux_sweep_defines.svh @@
// assertion macros shared by the duty meter rtl
`ifndef PWM_DUTY_AVERAGE_MUX_SWEEP_DEFINES_SVH
`define PWM_DUTY_AVERAGE_MUX_SWEEP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PDAMS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdams assertion failed");

// next-cycle implication, checked outside reset
`define PDAMS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdams assertion failed");

`endif

@@ rtl/core/pdams_pkg.sv @@
// types, constants and helpers of the pwm duty meter
`timescale 1ns / 1ps
`default_nettype none

package pdams_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd1;

  localparam logic [6:0] PERCENT_FULL   = 7'd100;
  localparam logic [6:0] SAMPLES_MAX    = 7'd64;
  localparam logic [6:0] SAMPLES_RESET  = 7'd10;
  localparam logic [6:0] COUNT_SAT      = 7'd127;
  localparam logic [4:0] CHANNELS_RESET = 5'd16;

  // high * 100 fits 39 bits; rounded sum fits 14 bits after the shift
  localparam int PROD_W = 39;
  localparam int AVG_W  = 14;
  localparam int REM_W  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SDIV_GO,
    ST_SDIV_WAIT,
    ST_ACC,
    ST_ROUND,
    ST_ADIV_GO,
    ST_ADIV_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [3:0] gray4(input logic [4:0] idx);
    gray4 = idx[3:0] ^ idx[4:1];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pdams_div.sv @@
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module pdams_div #(
  parameter int DIVIDEND_W = 55,
  parameter int QUOT_W     = 23,
  parameter int STEP_W     = $clog2(DIVIDEND_W + 1)
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [DIVIDEND_W-1:0]      dividend,
  input  wire logic [pdams_pkg::REM_W-1:0] divisor,
  input  wire logic [STEP_W-1:0]          steps,
  output logic      [QUOT_W-1:0]          quotient,
  output pdams_pkg::div_stat_t            stat
);
  import pdams_pkg::*;

  logic [DIVIDEND_W-1:0] dvd_r, dvd_nxt;
  logic [REM_W-1:0]      rem_r, rem_nxt;
  logic [REM_W-1:0]      dvs_r, dvs_nxt;
  logic [QUOT_W-1:0]     quo_r, quo_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  logic [REM_W:0] trial;
  logic [REM_W:0] diff;
  logic           fits;

  // shifted partial remainder against divisor, borrow tells the bit
  assign trial = {rem_r, dvd_r[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign fits  = ~diff[REM_W];

  always_comb begin
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = '0;
      cnt_nxt  = steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIVIDEND_W-2:0], 1'b0};
      rem_nxt = fits ? diff[REM_W-1:0] : trial[REM_W-1:0];
      quo_nxt = {quo_r[QUOT_W-2:0], fits};
      cnt_nxt = cnt_r - STEP_W'(1);
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

`default_nettype wire

@@ rtl/core/pwm_duty_average_mux_sweep.sv @@
// pwm duty meter: averages captured duty per mux channel over a gray-coded sweep
// restart, zero-period or post-sweep captures start no division, nor does a saturated sample
// a divided sample is the bit-serial division of high*100*2^F by the period
//   in the shared divider, before the sample is accumulated
// a channel-closing capture adds the rounding step, the average division and any wait for the output register
// reset: sync active-low rst_n clears the control state and loads the register defaults
`timescale 1ns / 1ps
`default_nettype none
`include "pwm_duty_average_mux_sweep_defines.svh"

module pwm_duty_average_mux_sweep #(
  parameter int MAX_CHANNELS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // capture channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_action,
  input  wire logic [31:0]                     in_period_count,
  input  wire logic [31:0]                     in_high_count,
  // result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [3:0]                           out_channel_code,
  output logic [6:0]                           out_duty_percent,
  output logic [3:0]                           out_next_mux_select,
  output logic                                 out_sweep_done,
  // register writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [pdams_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pdams_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pdams_pkg::*;

  localparam int QUOT_W = 7 + FRACTION_BITS;        // q7.f sample
  localparam int DIV_W  = PROD_W + FRACTION_BITS;   // dividend of the sample division
  localparam int ACC_W  = 13 + FRACTION_BITS;       // sum of up to 64 samples
  localparam int RND_W  = ACC_W + 1;                // sum plus rounding half
  localparam int STEP_W = $clog2(DIV_W + 1);

  localparam logic [QUOT_W-1:0] SAMPLE_FULL = {PERCENT_FULL, {FRACTION_BITS{1'b0}}};
  localparam logic [4:0]        CHAN_LIMIT  = 5'(MAX_CHANNELS);

  // configuration registers
  logic [6:0] cfg_samples_r;
  logic [4:0] cfg_channels_r;

  // sweep state
  state_t            state_r, state_nxt;
  logic [4:0]        chan_r, chan_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic [ACC_W-1:0]  acc_r, acc_nxt;
  logic              fin_r, fin_nxt;

  // working registers of the current capture
  logic [31:0]       period_r, period_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  logic [QUOT_W-1:0] sample_r, sample_nxt;
  logic [RND_W-1:0]  rnd_r, rnd_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  logic [3:0]        out_code_r, out_code_nxt;
  logic [6:0]        out_pct_r, out_pct_nxt;
  logic [3:0]        out_mux_r, out_mux_nxt;
  logic              out_done_r, out_done_nxt;

  // divider hookup
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [31:0]       div_divisor;
  logic [STEP_W-1:0] div_steps;
  logic [QUOT_W-1:0] div_quo;
  div_stat_t         div_stat;

  logic       in_acc;
  logic       capture_ok;
  logic       saturate;
  logic       out_free;
  logic [6:0] n_eff;
  logic [4:0] chans_eff;
  logic [6:0] cnt_inc;
  logic       last_chan;
  logic [6:0] pct;

  // effective register values, out-of-range counts clamp
  always_comb begin
    if (cfg_samples_r == 7'd0) begin
      n_eff = 7'd1;
    end else if (cfg_samples_r > SAMPLES_MAX) begin
      n_eff = SAMPLES_MAX;
    end else begin
      n_eff = cfg_samples_r;
    end
    if (cfg_channels_r == 5'd0) begin
      chans_eff = 5'd1;
    end else if (cfg_channels_r > CHAN_LIMIT) begin
      chans_eff = CHAN_LIMIT;
    end else begin
      chans_eff = cfg_channels_r;
    end
  end

  assign in_acc     = in_valid && !in_stall;
  assign capture_ok = !in_action && !fin_r && (in_period_count != 32'd0);
  assign saturate   = in_high_count >= in_period_count;
  assign out_free   = !out_valid_r || !out_stall;
  assign cnt_inc    = (cnt_r < COUNT_SAT) ? cnt_r + 7'd1 : cnt_r;
  assign last_chan  = ({1'b0, chan_r} + 6'd1) >= {1'b0, chans_eff};
  // average quotient never exceeds 100 in range, clamp anyway
  assign pct        = (div_quo > QUOT_W'(PERCENT_FULL)) ? PERCENT_FULL : div_quo[6:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && capture_ok) begin
          state_nxt = saturate ? ST_ACC : ST_SDIV_GO;
        end
      end
      ST_SDIV_GO:   state_nxt = ST_SDIV_WAIT;
      ST_SDIV_WAIT: if (div_stat.done) state_nxt = ST_ACC;
      ST_ACC:       state_nxt = (cnt_inc < n_eff) ? ST_IDLE : ST_ROUND;
      ST_ROUND:     state_nxt = ST_ADIV_GO;
      ST_ADIV_GO:   state_nxt = ST_ADIV_WAIT;
      ST_ADIV_WAIT: if (div_stat.done) state_nxt = ST_EMIT;
      ST_EMIT:      if (out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // control outputs: stall and divider operand selection
  always_comb begin
    in_stall     = 1'b1;
    div_start    = 1'b0;
    div_dividend = {prod_r, {FRACTION_BITS{1'b0}}};
    div_divisor  = period_r;
    div_steps    = STEP_W'(DIV_W);
    case (state_r)
      ST_IDLE:    in_stall = 1'b0;
      ST_SDIV_GO: div_start = 1'b1;
      ST_ADIV_GO: begin
        // rounded sum over 2^f, left-aligned so only its bits are walked
        div_start    = 1'b1;
        div_dividend = {rnd_r[RND_W-1:FRACTION_BITS], {(DIV_W - AVG_W){1'b0}}};
        div_divisor  = {25'd0, n_eff};
        div_steps    = STEP_W'(AVG_W);
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // datapath next values
  always_comb begin
    chan_nxt      = chan_r;
    cnt_nxt       = cnt_r;
    acc_nxt       = acc_r;
    fin_nxt       = fin_r;
    period_nxt    = period_r;
    prod_nxt      = prod_r;
    sample_nxt    = sample_r;
    rnd_nxt       = rnd_r;
    out_code_nxt  = out_code_r;
    out_pct_nxt   = out_pct_r;
    out_mux_nxt   = out_mux_r;
    out_done_nxt  = out_done_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_action) begin
            // restart the sweep, registers keep their values
            chan_nxt = '0;
            cnt_nxt  = '0;
            acc_nxt  = '0;
            fin_nxt  = 1'b0;
          end else if (capture_ok) begin
            period_nxt = in_period_count;
            prod_nxt   = PROD_W'(in_high_count) * PROD_W'(PERCENT_FULL);
            sample_nxt = SAMPLE_FULL;
          end
        end
      end
      ST_SDIV_WAIT: begin
        if (div_stat.done) sample_nxt = div_quo;
      end
      ST_ACC: begin
        acc_nxt = acc_r + ACC_W'(sample_r);
        cnt_nxt = cnt_inc;
      end
      ST_ROUND: begin
        rnd_nxt = RND_W'(acc_r) + (RND_W'(n_eff) << (FRACTION_BITS - 1));
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_code_nxt  = gray4(chan_r);
          out_pct_nxt   = pct;
          cnt_nxt       = '0;
          acc_nxt       = '0;
          if (last_chan) begin
            // select pins stay on the last channel
            fin_nxt      = 1'b1;
            out_mux_nxt  = gray4(chan_r);
            out_done_nxt = 1'b1;
          end else begin
            chan_nxt     = chan_r + 5'd1;
            out_mux_nxt  = gray4(chan_r + 5'd1);
            out_done_nxt = 1'b0;
          end
        end
      end
      default: begin
        out_valid_nxt = out_valid_r && out_stall;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      chan_r         <= '0;
      cnt_r          <= '0;
      acc_r          <= '0;
      fin_r          <= 1'b0;
      out_valid_r    <= 1'b0;
      cfg_samples_r  <= SAMPLES_RESET;
      cfg_channels_r <= CHANNELS_RESET;
    end else begin
      state_r     <= state_nxt;
      chan_r      <= chan_nxt;
      cnt_r       <= cnt_nxt;
      acc_r       <= acc_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLES:  cfg_samples_r  <= cfg_data[6:0];
          REG_CHANNELS: cfg_channels_r <= cfg_data[4:0];
          default: begin
            cfg_samples_r <= cfg_samples_r;
          end
        endcase
      end
    end
    period_r   <= period_nxt;
    prod_r     <= prod_nxt;
    sample_r   <= sample_nxt;
    rnd_r      <= rnd_nxt;
    out_code_r <= out_code_nxt;
    out_pct_r  <= out_pct_nxt;
    out_mux_r  <= out_mux_nxt;
    out_done_r <= out_done_nxt;
  end

  // shared serial divider: sample division, then average division
  pdams_div #(
    .DIVIDEND_W(DIV_W),
    .QUOT_W    (QUOT_W),
    .STEP_W    (STEP_W)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .steps   (div_steps),
    .quotient(div_quo),
    .stat    (div_stat)
  );

  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_channel_code    = out_code_r;
  assign out_duty_percent    = out_pct_r;
  assign out_next_mux_select = out_mux_r;
  assign out_sweep_done      = out_done_r;

  // a new result only comes out of the emit step
  `PDAMS_ASSERT_IMPL(a_out_from_emit, clk, rst_n, $rose(out_valid_r), $past(state_r == ST_EMIT))
  // divider finishes only while the sequencer waits for it
  `PDAMS_ASSERT_IMPL(a_done_in_wait, clk, rst_n, div_stat.done, (state_r == ST_SDIV_WAIT) || (state_r == ST_ADIV_WAIT))
  // divider is never restarted mid-division
  `PDAMS_ASSERT_IMPL(a_start_idle_div, clk, rst_n, div_start, !div_stat.busy)
  // per-channel sample count never runs past the largest average
  `PDAMS_ASSERT_NEXT(a_count_bound, clk, rst_n, state_r == ST_ACC, cnt_r <= SAMPLES_MAX)

endmodule

`default_nettype wire
